@@ rtl/csc_pkg.sv @@
// compressor start/stop control: shared constants, register indexes and types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;

  localparam int DELAY_BITS = 16;
  localparam int LP_LIMIT   = 30;
  localparam int LP_BITS    = $clog2(LP_LIMIT + 1);
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RESTART_DELAY  = 3'd0,
    CFG_START_DELAY    = 3'd1,
    CFG_PUMP_DOWN_TIME = 3'd2,
    CFG_LP_START_USE   = 3'd3,
    CFG_PUMP_DOWN_USE  = 3'd4,
    CFG_LP_STOP_USE    = 3'd5
  } csc_cfg_idx_t;

  typedef struct packed {
    logic [15:0] restart_delay;
    logic [15:0] start_delay;
    logic [15:0] pump_down_time;
    logic        lp_start_use;
    logic        pump_down_use;
    logic        lp_stop_use;
  } csc_cfg_t;

  typedef struct packed {
    logic                  started;
    logic [DELAY_BITS-1:0] restart_count;
    logic [DELAY_BITS-1:0] delay_count;
    logic [LP_BITS-1:0]    lp_integrator;
    logic                  permit;
    logic                  valve_state;
    logic                  compressor_state;
  } csc_state_t;

  typedef struct packed {
    logic run;
    logic low_pressure_ok;
    logic hard_kill;
  } csc_tick_t;

endpackage
`default_nettype wire

@@ rtl/csc_in_if.sv @@
// input channel: valid/ready handshake carrying one tick word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface csc_in_if;
  logic valid;
  logic ready;
  logic run;
  logic low_pressure_ok;
  logic hard_kill;

  modport source (output valid, output run, output low_pressure_ok, output hard_kill,
                  input ready);
  modport sink (input valid, input run, input low_pressure_ok, input hard_kill,
                output ready);
endinterface
`default_nettype wire

@@ rtl/csc_out_if.sv @@
// result channel: valid/ready handshake carrying valve and compressor drive
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface csc_out_if;
  logic valid;
  logic ready;
  logic valve_on;
  logic compressor_on;

  modport source (output valid, output valve_on, output compressor_on, input ready);
  modport sink (input valid, input valve_on, input compressor_on, output ready);
endinterface
`default_nettype wire

@@ rtl/csc_step.sv @@
// next-state logic for one tick of the compressor sequencer
// depends on csc_pkg
`timescale 1ns / 1ps
`default_nettype none
module csc_step (
  input  wire csc_pkg::csc_cfg_t   cfg,
  input  wire csc_pkg::csc_state_t cur,
  input  wire csc_pkg::csc_tick_t  tick,
  output csc_pkg::csc_state_t      nxt
);

  always_comb begin
    nxt = cur;
    if (!nxt.started) begin
      nxt.started       = 1'b1;
      nxt.restart_count = csc_pkg::DELAY_BITS'(cfg.restart_delay);
    end

    if (tick.run) begin
      if (nxt.restart_count == '0) begin
        nxt.valve_state = 1'b1;
        if (!nxt.permit) begin
          nxt.compressor_state = 1'b0;
          nxt.delay_count      = csc_pkg::DELAY_BITS'(cfg.start_delay);
        end else if (nxt.delay_count == '0) begin
          nxt.compressor_state = 1'b1;
        end
        if (cfg.lp_start_use) begin
          if (tick.low_pressure_ok) begin
            if (nxt.lp_integrator >= csc_pkg::LP_BITS'(csc_pkg::LP_LIMIT)) begin
              nxt.permit = 1'b1;
            end else begin
              nxt.lp_integrator = nxt.lp_integrator + 1'b1;
            end
          end else begin
            if (nxt.lp_integrator == '0) begin
              nxt.permit = 1'b0;
            end else begin
              nxt.lp_integrator = nxt.lp_integrator - 1'b1;
            end
          end
        end else begin
          nxt.permit = 1'b1;
        end
      end
    end else begin
      nxt.lp_integrator = '0;
      if (nxt.valve_state) begin
        nxt.valve_state   = 1'b0;
        nxt.delay_count   = csc_pkg::DELAY_BITS'(cfg.pump_down_time);
        nxt.restart_count = csc_pkg::DELAY_BITS'(cfg.restart_delay);
      end
      if ((nxt.delay_count == '0 && cfg.pump_down_use) ||
          (cfg.lp_stop_use && !tick.low_pressure_ok) || tick.hard_kill) begin
        nxt.permit           = 1'b0;
        nxt.compressor_state = 1'b0;
      end
    end

    if (nxt.delay_count != '0) begin
      nxt.delay_count = nxt.delay_count - 1'b1;
    end
    if (nxt.restart_count != '0) begin
      nxt.restart_count = nxt.restart_count - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/compressor_start_stop_control_top.sv @@
// compressor start/stop control top level: config registers, state and result register
// depends on csc_pkg, csc_in_if, csc_out_if, csc_step
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input word is one tick and yields exactly one result word (valve and
// compressor drive after that tick) in the following cycle. A new word is accepted every
// cycle while the result register is empty or being drained; throughput is one tick per
// cycle, set by the combinational next-state logic in csc_step. Configuration writes take
// effect at the clock edge of the write and should only be made while the block is idle.
module compressor_start_stop_control_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  csc_in_if.sink                               in_ch,
  csc_out_if.source                            out_ch,
  input  wire                                  cfg_we,
  input  wire [csc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire [csc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  csc_pkg::csc_cfg_t   cfg_r;
  csc_pkg::csc_state_t state_r;
  csc_pkg::csc_state_t state_nxt;
  csc_pkg::csc_tick_t  tick;
  logic                out_valid_r;
  logic                valve_r;
  logic                comp_r;
  logic                in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick        = '{run: in_ch.run, low_pressure_ok: in_ch.low_pressure_ok,
                         hard_kill: in_ch.hard_kill};

  csc_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .tick (tick),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (csc_pkg::csc_cfg_idx_t'(cfg_index))
        csc_pkg::CFG_RESTART_DELAY:  cfg_r.restart_delay  <= cfg_wdata[15:0];
        csc_pkg::CFG_START_DELAY:    cfg_r.start_delay    <= cfg_wdata[15:0];
        csc_pkg::CFG_PUMP_DOWN_TIME: cfg_r.pump_down_time <= cfg_wdata[15:0];
        csc_pkg::CFG_LP_START_USE:   cfg_r.lp_start_use   <= cfg_wdata[0];
        csc_pkg::CFG_PUMP_DOWN_USE:  cfg_r.pump_down_use  <= cfg_wdata[0];
        csc_pkg::CFG_LP_STOP_USE:    cfg_r.lp_stop_use    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      valve_r <= state_nxt.valve_state;
      comp_r  <= state_nxt.compressor_state;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.valve_on      = valve_r;
  assign out_ch.compressor_on = comp_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_lp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lp_integrator <= csc_pkg::LP_BITS'(csc_pkg::LP_LIMIT))
    else $error("low-pressure integrator out of range");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.started |=> state_r.started)
    else $error("started flag cleared without reset");

  a_stop_clears_lp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.run) |=> (state_r.lp_integrator == '0))
    else $error("stop tick left integrator nonzero");
`endif

endmodule
`default_nettype wire
